@@ rtl/proxy_connection_tracker_top_macros.svh @@
// ---------------------------------------------------------------------------
// proxy_connection_tracker_top_macros
// Assertion macros for the connection tracker.
// ---------------------------------------------------------------------------
`ifndef PROXY_CONNECTION_TRACKER_TOP_MACROS_SVH
`define PROXY_CONNECTION_TRACKER_TOP_MACROS_SVH
// assert that a implies b at the same edge
`define PCT_ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b at the next edge
`define PCT_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ rtl/pct_pkg.sv @@
// ---------------------------------------------------------------------------
// pct_pkg
// Shared constants and types of the proxy connection tracker.
// ---------------------------------------------------------------------------
package pct_pkg;
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_BACKENDS_DEF  = 256;
    localparam logic [23:0] TAG_MASK = 24'hFFFFFF;
    localparam logic [7:0]  BACKEND_MASK = 8'hFF;

    localparam logic [2:0] ACT_CONNECT      = 3'd0;
    localparam logic [2:0] ACT_RECV_CLIENT  = 3'd1;
    localparam logic [2:0] ACT_RECV_BACKEND = 3'd2;
    localparam logic [2:0] ACT_SEND_BACKEND = 3'd3;
    localparam logic [2:0] ACT_SEND_CLIENT  = 3'd4;
    localparam logic [2:0] ACT_REJECT       = 3'd5;
    localparam logic [2:0] ACT_RELEASE      = 3'd6;
    localparam logic [2:0] ACT_REARM        = 3'd7;

    localparam logic [2:0] OP_CONN_DONE    = 3'd0;
    localparam logic [2:0] OP_RECV_CLIENT  = 3'd1;
    localparam logic [2:0] OP_SEND_BACKEND = 3'd2;
    localparam logic [2:0] OP_RECV_BACKEND = 3'd3;
    localparam logic [2:0] OP_SEND_CLIENT  = 3'd4;

    localparam logic REG_NUM_BACKENDS = 1'b0;
    localparam logic REG_RECV_LIMIT   = 1'b1;

    // classified event handed from front to back
    typedef struct packed {
        logic        kind;
        logic [2:0]  op;
        logic [23:0] slot_id;
        logic [31:0] tag_generation;
        logic [31:0] outcome;
        logic        more;
    } event_t;

    // one result beat
    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] out_slot;
        logic [31:0] out_generation;
        logic [7:0]  backend_index;
        logic [30:0] length;
        logic [30:0] client_handle;
        logic        last;
    } result_t;
endpackage

@@ rtl/pct_front.sv @@
// ---------------------------------------------------------------------------
// pct_front
// Input stage: takes event beats and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module pct_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pct_pkg::event_t s_evt,
    output logic            q_valid,
    input  logic            q_pop,
    output pct_pkg::event_t q_evt
);
    import pct_pkg::*;

    event_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_evt    = mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_evt;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

@@ rtl/pct_back.sv @@
// ---------------------------------------------------------------------------
// pct_back
// Slot engine: clears the table after reset, then reads, updates and
// writes back one slot per event and emits up to two result beats.
// ---------------------------------------------------------------------------
module pct_back #(
    parameter int TABLE_ENTRIES = pct_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_BACKENDS  = pct_pkg::MAX_BACKENDS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_addr,
    input  logic [15:0]      cfg_wdata,
    input  logic             q_valid,
    output logic             q_pop,
    input  pct_pkg::event_t  q_evt,
    output logic             m_valid,
    input  logic             m_ready,
    output pct_pkg::result_t m_res
);
    import pct_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int BW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_OUT0  = 3'd4;
    localparam logic [2:0] ST_OUT1  = 3'd5;
    localparam logic [2:0] ST_READ2 = 3'd6;

    // slot entry: generation, outstanding, closing, live
    logic [35:0] slot_mem [TABLE_ENTRIES];
    logic [AW-1:0] free_mem [TABLE_ENTRIES];
    logic [35:0]   slot_rd_reg;
    logic [AW-1:0] free_rd_reg;

    logic [2:0]    state_reg;
    logic [AW-1:0] clr_reg;
    logic [CW-1:0] free_count_reg;
    logic [BW-1:0] next_backend_reg;
    logic [8:0]    num_backends_reg;
    logic [15:0]   recv_limit_reg;
    event_t        evt_reg;
    logic [AW-1:0] slot_reg;
    result_t       res_reg [2];
    logic          two_reg;

    // slot write port and free stack write port
    logic          slot_we, free_we;
    logic [AW-1:0] slot_wa, free_wa, free_wd;
    logic [35:0]   slot_wd;

    // backend count limited to the legal range
    logic [8:0] nb_eff;
    always_comb begin
        nb_eff = num_backends_reg;
        if (nb_eff == 9'd0) nb_eff = 9'd1;
        if (nb_eff > 9'(MAX_BACKENDS)) nb_eff = 9'(MAX_BACKENDS);
    end

    // memories
    always_ff @(posedge aclk) begin
        if (slot_we) slot_mem[slot_wa] <= slot_wd;
        slot_rd_reg <= slot_mem[slot_reg];
    end
    always_ff @(posedge aclk) begin
        if (free_we) free_mem[free_wa] <= free_wd;
        free_rd_reg <= free_mem[AW'(free_count_reg - CW'(1))];
    end

    // execute step decode
    logic        in_range, neg, zero, fail, rel, stack_ok;
    logic [31:0] g, gnew;
    logic [1:0]  outs, odec;
    logic        clos, live;
    result_t     r0, r1;
    logic [1:0]  nres;
    logic [BW-1:0] bidx;
    logic [8:0]  bnext;
    logic [30:0] rl;

    always_comb begin
        g      = slot_rd_reg[35:4];
        outs   = slot_rd_reg[3:2];
        clos   = slot_rd_reg[1];
        live   = slot_rd_reg[0];
        neg    = evt_reg.outcome[31];
        zero   = (evt_reg.outcome == 32'd0);
        rl     = {15'd0, recv_limit_reg};
        in_range = ({8'd0, evt_reg.slot_id} < 32'(TABLE_ENTRIES));
        odec   = (outs != 2'd0) ? outs - 2'd1 : 2'd0;
        gnew   = g + 32'd1;
        r0     = '0;
        r1     = '0;
        nres   = 2'd0;
        fail   = 1'b0;
        rel    = 1'b0;
        slot_we = 1'b0;
        slot_wa = slot_reg;
        slot_wd = slot_rd_reg;
        free_we = 1'b0;
        free_wa = AW'(free_count_reg);
        free_wd = slot_reg;
        stack_ok = (free_count_reg < CW'(TABLE_ENTRIES));
        bidx   = ({1'b0, next_backend_reg} < 9'(nb_eff)) ? next_backend_reg : '0;
        bnext  = 9'(bidx) + 9'd1;
        if (state_reg == ST_CLEAR) begin
            slot_we = 1'b1;
            slot_wa = clr_reg;
            slot_wd = '0;
            free_we = 1'b1;
            free_wa = clr_reg;
            free_wd = clr_reg;
        end else if (state_reg == ST_EXEC) begin
            if (!evt_reg.kind) begin
                if (!neg) begin
                    if (free_count_reg != '0) begin
                        slot_we = 1'b1;
                        slot_wd = {gnew, 2'd1, 1'b0, 1'b1};
                        r0.action = ACT_CONNECT;
                        r0.out_slot = 12'(slot_reg);
                        r0.out_generation = gnew;
                        r0.backend_index = 8'(bidx);
                        r0.client_handle = evt_reg.outcome[30:0];
                    end else begin
                        r0.action = ACT_REJECT;
                        r0.client_handle = evt_reg.outcome[30:0];
                    end
                    nres = 2'd1;
                    if (!evt_reg.more) begin
                        r1.action = ACT_REARM;
                        nres = 2'd2;
                    end
                end else if (!evt_reg.more) begin
                    r0.action = ACT_REARM;
                    nres = 2'd1;
                end
            end else if (in_range && g == evt_reg.tag_generation && live) begin
                slot_we = 1'b1;
                slot_wd = {g, odec, clos, live};
                r0.out_slot = 12'(slot_reg);
                r0.out_generation = g;
                r1.out_slot = 12'(slot_reg);
                r1.out_generation = g;
                if (clos) begin
                    rel = (odec == 2'd0);
                end else begin
                    unique case (evt_reg.op) inside
                        OP_CONN_DONE: begin
                            if (neg) fail = 1'b1;
                            else begin
                                r0.action = ACT_RECV_CLIENT; r0.length = rl;
                                r1.action = ACT_RECV_BACKEND; r1.length = rl;
                                nres = 2'd2;
                                slot_wd[3:2] = odec + 2'd2;
                            end
                        end
                        OP_RECV_CLIENT, OP_RECV_BACKEND: begin
                            if (neg || zero) fail = 1'b1;
                            else begin
                                r0.action = (evt_reg.op == OP_RECV_CLIENT) ?
                                            ACT_SEND_BACKEND : ACT_SEND_CLIENT;
                                r0.length = evt_reg.outcome[30:0];
                                nres = 2'd1;
                                slot_wd[3:2] = odec + 2'd1;
                            end
                        end
                        OP_SEND_BACKEND, OP_SEND_CLIENT: begin
                            if (neg) fail = 1'b1;
                            else begin
                                r0.action = (evt_reg.op == OP_SEND_BACKEND) ?
                                            ACT_RECV_CLIENT : ACT_RECV_BACKEND;
                                r0.length = rl;
                                nres = 2'd1;
                                slot_wd[3:2] = odec + 2'd1;
                            end
                        end
                        default: ;
                    endcase
                    if (fail) begin
                        slot_wd[1] = 1'b1;
                        rel = (odec == 2'd0);
                    end
                end
                if (rel) begin
                    slot_wd = {g, 2'd0, 1'b0, 1'b0};
                    r0 = '0;
                    r0.action = ACT_RELEASE;
                    r0.out_slot = 12'(slot_reg);
                    r0.out_generation = g;
                    nres = 2'd1;
                    free_we = stack_ok;
                end
            end
            if (nres == 2'd1) r0.last = 1'b1;
            if (nres == 2'd2) r1.last = 1'b1;
        end
    end

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
    assign m_res   = (state_reg == ST_OUT1) ? res_reg[1] : res_reg[0];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_backends_reg <= 9'd1;
            recv_limit_reg   <= 16'd4096;
        end else if (cfg_we && cfg_addr[15:1] == 15'd0) begin
            if (cfg_addr[0] == REG_NUM_BACKENDS) num_backends_reg <= cfg_wdata[8:0];
            else recv_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            evt_reg <= q_evt;
        end
        if (state_reg == ST_EXEC) begin
            res_reg[0] <= r0;
            res_reg[1] <= r1;
            two_reg <= (nres == 2'd2);
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            free_count_reg   <= CW'(TABLE_ENTRIES);
            next_backend_reg <= '0;
            slot_reg         <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(TABLE_ENTRIES - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= ST_READ;
                        slot_reg  <= AW'(q_evt.slot_id);
                    end
                end
                ST_READ: begin
                    // free stack top is registered now; pick slot for accepts
                    if (!evt_reg.kind) slot_reg <= free_rd_reg;
                    state_reg <= (evt_reg.kind) ? ST_EXEC : ST_READ2;
                end
                ST_READ2: state_reg <= ST_EXEC;
                ST_EXEC: begin
                    if (!evt_reg.kind && !neg && free_count_reg != '0) begin
                        free_count_reg   <= free_count_reg - CW'(1);
                        next_backend_reg <= (bnext >= nb_eff) ? '0 : BW'(bnext);
                    end
                    if (free_we) free_count_reg <= free_count_reg + CW'(1);
                    state_reg <= (nres == 2'd0) ? ST_IDLE : ST_OUT0;
                end
                ST_OUT0: if (m_ready) state_reg <= two_reg ? ST_OUT1 : ST_IDLE;
                ST_OUT1: if (m_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/proxy_connection_tracker_top.sv @@
// ---------------------------------------------------------------------------
// proxy_connection_tracker_top
// Connection slot tracker with generation tags and a free slot stack.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries events (accept or completion, told apart by s_tuser);
//   m_ channel carries the resulting actions, tlast on the final beat.
//   cfg_we/cfg_addr/cfg_wdata write num_backends (0) and recv_limit (1).
//   Each event is queued in a two-beat input queue; the slot engine then
//   pops it (IDLE), reads its slot (READ; an accept first takes the slot
//   from the registered free stack top in READ and reads it in READ2),
//   updates and writes back the slot (EXEC), and presents one result beat
//   per cycle while m_tready is high (OUT0, OUT1). The engine takes the
//   next event only once the current one has been executed and all its
//   result beats are taken.
//   After reset the engine clears the slot table and rebuilds the free
//   stack, while the queue still takes up to two beats.
//   A stalled m_tready holds the engine; the queue keeps taking events
//   until it holds two, then s_tready drops.
// ---------------------------------------------------------------------------
`include "proxy_connection_tracker_top_macros.svh"
module proxy_connection_tracker_top #(
    parameter int TABLE_ENTRIES = pct_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_BACKENDS  = pct_pkg::MAX_BACKENDS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: op, slot_id, tag_generation, outcome, more, 4 pad bits
    input  logic [95:0]  s_tdata,
    // tuser: kind
    input  logic         s_tuser,
    input  logic         m_tready,
    output logic         m_tvalid,
    // tdata: action, out_slot, out_generation, backend_index, length,
    // client_handle, 3 pad bits
    output logic [119:0] m_tdata,
    output logic         m_tlast
);
    import pct_pkg::*;

    event_t  s_evt, q_evt;
    result_t res;
    logic    q_valid, q_pop;

    assign s_evt.kind           = s_tuser;
    assign s_evt.op             = s_tdata[2:0];
    assign s_evt.slot_id        = s_tdata[26:3];
    assign s_evt.tag_generation = s_tdata[58:27];
    assign s_evt.outcome        = s_tdata[90:59];
    assign s_evt.more           = s_tdata[91];

    pct_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_evt,
        .q_valid, .q_pop, .q_evt
    );

    pct_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_BACKENDS(MAX_BACKENDS)) u_back (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .q_valid, .q_pop, .q_evt,
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res)
    );

    assign m_tdata = {3'b0, res.client_handle, res.length, res.backend_index,
                      res.out_generation, res.out_slot, res.action};
    assign m_tlast = res.last;

    `PCT_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, q_pop, q_valid)
    `PCT_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))
endmodule

@@ tb/tb_proxy_connection_tracker_checker.sv @@
// ---------------------------------------------------------------------------
// tb_proxy_connection_tracker_checker
// Watches the event, action and register ports of the connection tracker,
// keeps its own copy of the slot table and free stack, works out the
// actions each accepted event should produce and compares every action beat
// field by field against the oldest outstanding one.
// ---------------------------------------------------------------------------
module tb_proxy_connection_tracker_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           actions_pending
);
    import pct_pkg::*;

    localparam int SLOTS = TABLE_ENTRIES_DEF;

    // shadow slot table
    logic [31:0] gen_tab   [SLOTS];
    logic [1:0]  busy_tab  [SLOTS];
    logic        close_tab [SLOTS];
    logic        live_tab  [SLOTS];
    logic [11:0] free_stk  [SLOTS];
    int          free_cnt;
    int          rr_next;
    logic [8:0]  backends;
    logic [15:0] rx_limit;

    result_t     action_q[$];

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            gen_tab[i]   = '0;
            busy_tab[i]  = '0;
            close_tab[i] = 1'b0;
            live_tab[i]  = 1'b0;
            free_stk[i]  = 12'(i);
        end
        free_cnt   = SLOTS;
        rr_next    = 0;
        backends   = 9'd1;
        rx_limit   = 16'd4096;
        fail_count = 0;
    end

    assign actions_pending = action_q.size();

    task automatic report(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic result_t mk_action(logic [2:0] act, logic [11:0] slot,
                                          logic [31:0] gen, logic [7:0] be,
                                          logic [30:0] len, logic [30:0] hdl);
        result_t r;
        r.action         = act;
        r.out_slot       = slot;
        r.out_generation = gen;
        r.backend_index  = be;
        r.length         = len;
        r.client_handle  = hdl;
        r.last           = 1'b0;
        return r;
    endfunction

    // round-robin backend pick with clamped count
    function automatic logic [7:0] next_backend_pick();
        int n;
        int idx;
        n   = (backends == 0) ? 1 : ((backends > MAX_BACKENDS_DEF) ? MAX_BACKENDS_DEF
                                                                    : int'(backends));
        idx = (rr_next < n) ? rr_next : 0;
        rr_next = (idx + 1 >= n) ? 0 : idx + 1;
        return 8'(idx);
    endfunction

    // free the slot once it is closing and nothing is outstanding
    function automatic void try_release(logic [11:0] s, ref result_t acts[$]);
        if (!close_tab[s] || busy_tab[s] != 0)
            return;
        close_tab[s] = 1'b0;
        live_tab[s]  = 1'b0;
        if (free_cnt < SLOTS) begin
            free_stk[free_cnt] = s;
            free_cnt++;
        end
        acts.push_back(mk_action(ACT_RELEASE, s, gen_tab[s], '0, '0, '0));
    endfunction

    // expected actions of one event beat
    function automatic void predict_actions(logic kind_in, logic [95:0] d);
        logic        kind;
        logic [2:0]  op;
        logic [23:0] sid;
        logic [31:0] gen;
        logic [31:0] outc;
        logic        more;
        logic        neg;
        logic        fail;
        logic [11:0] s;
        logic [31:0] g;
        result_t     acts[$];
        kind = kind_in;
        op   = d[2:0];
        sid  = d[26:3];
        gen  = d[58:27];
        outc = d[90:59];
        more = d[91];
        neg  = outc[31];
        fail = 1'b0;
        if (!kind) begin
            if (!neg) begin
                if (free_cnt > 0) begin
                    free_cnt--;
                    s = free_stk[free_cnt];
                    gen_tab[s]   = gen_tab[s] + 1;
                    close_tab[s] = 1'b0;
                    live_tab[s]  = 1'b1;
                    acts.push_back(mk_action(ACT_CONNECT, s, gen_tab[s],
                                             next_backend_pick(), '0, outc[30:0]));
                    busy_tab[s] = 2'd1;
                end else begin
                    acts.push_back(mk_action(ACT_REJECT, '0, '0, '0, '0, outc[30:0]));
                end
            end
            if (!more)
                acts.push_back(mk_action(ACT_REARM, '0, '0, '0, '0, '0));
        end else begin
            if (sid >= SLOTS)
                return;
            s = sid[11:0];
            if (gen_tab[s] != gen || !live_tab[s])
                return;
            if (busy_tab[s] != 0)
                busy_tab[s]--;
            if (close_tab[s]) begin
                try_release(s, acts);
            end else begin
                g = gen_tab[s];
                case (op)
                    OP_CONN_DONE: begin
                        if (neg) begin
                            fail = 1'b1;
                        end else begin
                            acts.push_back(mk_action(ACT_RECV_CLIENT, s, g, '0,
                                                     31'(rx_limit), '0));
                            acts.push_back(mk_action(ACT_RECV_BACKEND, s, g, '0,
                                                     31'(rx_limit), '0));
                            busy_tab[s] = busy_tab[s] + 2'd2;
                        end
                    end
                    OP_RECV_CLIENT, OP_RECV_BACKEND: begin
                        if (neg || outc == 0) begin
                            fail = 1'b1;
                        end else begin
                            acts.push_back(mk_action((op == OP_RECV_CLIENT) ?
                                                     ACT_SEND_BACKEND : ACT_SEND_CLIENT,
                                                     s, g, '0, outc[30:0], '0));
                            busy_tab[s] = busy_tab[s] + 2'd1;
                        end
                    end
                    OP_SEND_BACKEND, OP_SEND_CLIENT: begin
                        if (neg) begin
                            fail = 1'b1;
                        end else begin
                            acts.push_back(mk_action((op == OP_SEND_BACKEND) ?
                                                     ACT_RECV_CLIENT : ACT_RECV_BACKEND,
                                                     s, g, '0, 31'(rx_limit), '0));
                            busy_tab[s] = busy_tab[s] + 2'd1;
                        end
                    end
                    default: ;
                endcase
                if (fail) begin
                    close_tab[s] = 1'b1;
                    try_release(s, acts);
                end
            end
        end
        if (acts.size() > 0)
            acts[acts.size() - 1].last = 1'b1;
        foreach (acts[i])
            action_q.push_back(acts[i]);
    endfunction

    // all ports are driven on the clock edge, so pre-edge values are read here
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_addr == 16'(REG_NUM_BACKENDS))
                    backends = cfg_wdata[8:0];
                else if (cfg_addr == 16'(REG_RECV_LIMIT))
                    rx_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                predict_actions(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                got.action         = m_tdata[2:0];
                got.out_slot       = m_tdata[14:3];
                got.out_generation = m_tdata[46:15];
                got.backend_index  = m_tdata[54:47];
                got.length         = m_tdata[85:55];
                got.client_handle  = m_tdata[116:86];
                got.last           = m_tlast;
                if (action_q.size() == 0) begin
                    report($sformatf("unexpected action beat %p", got));
                end else begin
                    want = action_q.pop_front();
                    if (got.action !== want.action)
                        report($sformatf("action %0d, expected %0d",
                                         got.action, want.action));
                    if (got.out_slot !== want.out_slot)
                        report($sformatf("slot %0d, expected %0d",
                                         got.out_slot, want.out_slot));
                    if (got.out_generation !== want.out_generation)
                        report($sformatf("generation %0h, expected %0h",
                                         got.out_generation, want.out_generation));
                    if (got.backend_index !== want.backend_index)
                        report($sformatf("backend %0d, expected %0d",
                                         got.backend_index, want.backend_index));
                    if (got.length !== want.length)
                        report($sformatf("length %0d, expected %0d",
                                         got.length, want.length));
                    if (got.client_handle !== want.client_handle)
                        report($sformatf("client handle %0h, expected %0h",
                                         got.client_handle, want.client_handle));
                    if (got.last !== want.last)
                        report($sformatf("tlast %0b, expected %0b",
                                         got.last, want.last));
                end
            end
        end
    end
endmodule

@@ tb/tb_proxy_connection_tracker_top.sv @@
// ---------------------------------------------------------------------------
// tb_proxy_connection_tracker_top
// Drives accept and completion events into the connection tracker, with
// completions built from the actions it has issued, under random gaps and
// back-pressure, and leaves prediction and comparison to the checker.
// ---------------------------------------------------------------------------
module tb_proxy_connection_tracker_top;
    import pct_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [15:0]  cfg_addr;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         s_tuser;
    logic         m_tready;
    logic         m_tvalid;
    logic [119:0] m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           actions_pending;

    // an action issued by the block that still awaits its completion
    typedef struct {
        logic [2:0]  op;
        logic [11:0] slot;
        logic [31:0] gen;
    } inflight_t;

    inflight_t    inflight_q[$];
    int           cyc;
    int           rx_cyc;
    int           n_accepts;
    int           n_completions;
    logic         steady_tx;

    proxy_connection_tracker_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    tb_proxy_connection_tracker_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .actions_pending (actions_pending)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // run limit
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("FAIL proxy_connection_tracker_top");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, one stretch always ready
    initial begin
        m_tready = 1'b0;
        rx_cyc   = 0;
        forever begin
            @(posedge aclk);
            rx_cyc++;
            if (rx_cyc >= 6000 && rx_cyc < 6600)
                m_tready <= 1'b0;
            else if (rx_cyc >= 8000 && rx_cyc < 11000)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 35);
        end
    end

    // collect issued actions as completion candidates
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            case (m_tdata[2:0])
                ACT_CONNECT:      inflight_q.push_back('{OP_CONN_DONE,
                                                         m_tdata[14:3], m_tdata[46:15]});
                ACT_RECV_CLIENT:  inflight_q.push_back('{OP_RECV_CLIENT,
                                                         m_tdata[14:3], m_tdata[46:15]});
                ACT_RECV_BACKEND: inflight_q.push_back('{OP_RECV_BACKEND,
                                                         m_tdata[14:3], m_tdata[46:15]});
                ACT_SEND_BACKEND: inflight_q.push_back('{OP_SEND_BACKEND,
                                                         m_tdata[14:3], m_tdata[46:15]});
                ACT_SEND_CLIENT:  inflight_q.push_back('{OP_SEND_CLIENT,
                                                         m_tdata[14:3], m_tdata[46:15]});
                default: ;
            endcase
        end
    end

    // one event beat; tvalid stays high after acceptance unless a gap follows
    task automatic send_event(input logic kind, input logic [2:0] op,
                              input logic [23:0] sid, input logic [31:0] gen,
                              input logic [31:0] outc, input logic more);
        if (!steady_tx && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, more, outc, gen, sid, op};
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind) n_completions++;
        else      n_accepts++;
    endtask

    // stop offering and wait until every expected action has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (actions_pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [15:0] nb, input logic [15:0] lim);
        cfg_we    <= 1'b1;
        cfg_addr  <= 16'(REG_NUM_BACKENDS);
        cfg_wdata <= nb;
        @(posedge aclk);
        cfg_addr  <= 16'(REG_RECV_LIMIT);
        cfg_wdata <= lim;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] rand_count();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(1, 16));
            1:       return 32'h7FFF_FFFF;
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    // complete an issued action; some outcomes fail or close the slot
    task automatic complete_one(input int pick);
        inflight_t   a;
        logic [31:0] outc;
        int          r;
        a = inflight_q[pick];
        inflight_q.delete(pick);
        r = $urandom_range(99);
        if (r < 6)
            outc = {1'b1, 31'($urandom)};
        else if (r < 14 && (a.op == OP_RECV_CLIENT || a.op == OP_RECV_BACKEND))
            outc = '0;
        else
            outc = rand_count();
        send_event(1'b1, a.op, {12'b0, a.slot}, a.gen, outc, 1'($urandom));
    endtask

    // anything that should be dropped or only decrement
    task automatic send_noise();
        inflight_t a;
        int        k;
        case ($urandom_range(3))
            0: send_event(1'b1, 3'($urandom), 24'($urandom), $urandom, $urandom,
                          1'($urandom));
            1: send_event(1'b1, 3'($urandom), 24'($urandom_range(4095)), $urandom,
                          $urandom, 1'($urandom));
            default: begin
                if (inflight_q.size() == 0) begin
                    send_event(1'b1, OP_CONN_DONE, 24'hFFFFFF, $urandom, $urandom, 1'b0);
                end else begin
                    k = $urandom_range(inflight_q.size() - 1);
                    a = inflight_q[k];
                    if ($urandom_range(1))
                        send_event(1'b1, a.op, {12'b0, a.slot}, a.gen + 1, $urandom,
                                   1'($urandom));
                    else
                        send_event(1'b1, 3'($urandom_range(5, 7)), {12'b0, a.slot},
                                   a.gen, $urandom, 1'($urandom));
                end
            end
        endcase
    endtask

    initial begin
        int cnt;
        int r;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        n_accepts  = 0;
        n_completions = 0;
        steady_tx  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: accept extremes, drops, then a relay on the first slot
        write_regs(16'd3, 16'd1);
        send_event(1'b0, 3'd7, 24'hFFFFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_event(1'b0, 3'd0, 24'd0, 32'd0, 32'h7FFF_FFFF, 1'b1);
        send_event(1'b0, 3'd0, 24'd0, 32'd0, 32'h8000_0000, 1'b0);
        send_event(1'b0, 3'd0, 24'd0, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_event(1'b1, OP_CONN_DONE, 24'hFFFFFF, 32'd1, 32'd0, 1'b0);
        send_event(1'b1, OP_CONN_DONE, 24'd4096, 32'd1, 32'd0, 1'b0);
        send_event(1'b1, OP_CONN_DONE, 24'd5, 32'd0, 32'd0, 1'b0);
        drain();
        // stale generation, unknown op, then the real connect completion
        send_event(1'b1, inflight_q[0].op, {12'b0, inflight_q[0].slot},
                   inflight_q[0].gen + 1, 32'd0, 1'b0);
        send_event(1'b1, 3'd6, {12'b0, inflight_q[0].slot}, inflight_q[0].gen,
                   32'd0, 1'b0);
        complete_one(0);
        drain();
        for (int i = 0; i < 6 && inflight_q.size() > 0; i++) begin
            send_event(1'b1, inflight_q[0].op, {12'b0, inflight_q[0].slot},
                       inflight_q[0].gen, (i == 5) ? 32'd0 : 32'd100, 1'b1);
            inflight_q.delete(0);
        end
        drain();

        // random relays under several register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_regs(16'd256, 16'd65535);
                1: write_regs(16'd0, 16'd4096);
                2: write_regs(16'd511, 16'd1234);
                default: write_regs(16'd1, 16'd65535);
            endcase
            cnt = 0;
            while (cnt < 170) begin
                steady_tx = (ph == 2 && cnt >= 40 && cnt < 150);
                r = $urandom_range(99);
                if (r < 25 || inflight_q.size() == 0) begin
                    send_event(1'b0, 3'($urandom), 24'($urandom), $urandom,
                               ($urandom_range(19) == 0) ? {1'b1, 31'($urandom)}
                                                         : rand_count(),
                               1'($urandom));
                    cnt++;
                end else if (r < 88) begin
                    complete_one($urandom_range(inflight_q.size() - 1));
                    cnt++;
                end else begin
                    send_noise();
                end
            end
            steady_tx = 1'b0;
            drain();
        end

        // fail a batch of open actions, then take a few more accepts
        write_regs(16'd2, 16'd512);
        for (int i = 0; i < 20 && inflight_q.size() > 0; i++) begin
            send_event(1'b1, inflight_q[0].op, {12'b0, inflight_q[0].slot},
                       inflight_q[0].gen, 32'hFFFF_FFFF, 1'b1);
            inflight_q.delete(0);
        end
        for (int i = 0; i < 24; i++)
            send_event(1'b0, 3'd0, 24'd0, 32'd0, rand_count(), 1'($urandom));
        drain();

        $display("covered %0d accepts and %0d completions over six register settings,",
                 n_accepts, n_completions);
        $display("including failed relays, stale and dropped completions and back-pressure");
        if (fail_count == 0 && actions_pending == 0) begin
            $display("PASS proxy_connection_tracker_top");
        end else begin
            $display("FAIL proxy_connection_tracker_top");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/pct_pkg.sv
rtl/pct_front.sv
rtl/pct_back.sv
rtl/proxy_connection_tracker_top.sv
tb/tb_proxy_connection_tracker_checker.sv
tb/tb_proxy_connection_tracker_top.sv
